>>> rtl/core/nwed_pkg.sv
// Shared types, constants and helpers for the nearest-word edit distance block.
package nwed_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int CH_W        = 8;
    localparam int DIST_W      = 7;
    localparam int COUNT_W     = 20;
    localparam int IN_DATA_W   = 8;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 3;

    localparam logic [DIST_W-1:0]  DIST_MAX   = 7'd127;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 20'hFFFFF;
    localparam logic [1:0]         SUB_COST   = 2'd2;
    localparam logic [1:0]         INDEL_COST = 2'd1;

    typedef enum logic [1:0] {
        CMD_QCHAR = 2'd0,
        CMD_QEND  = 2'd1,
        CMD_DCHAR = 2'd2,
        CMD_DEND  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        VERDICT_NEW   = 2'd0,
        VERDICT_TIE   = 2'd1,
        VERDICT_WORSE = 2'd2
    } verdict_t;

    // One dictionary character on its way down the row of cells
    typedef struct packed {
        logic              valid;
        logic [CH_W-1:0]   ch;
        logic [DIST_W-1:0] diag;
        logic [DIST_W-1:0] left;
    } nwed_token_t;

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {{(DIST_W-1){1'b0}}, b};
        return (s > {1'b0, DIST_MAX}) ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] min3(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b,
                                               input logic [DIST_W-1:0] c);
        logic [DIST_W-1:0] m;
        m = (a <= b) ? a : b;
        return (m <= c) ? m : c;
    endfunction

endpackage

>>> rtl/core/nearest_word_edit_distance_top.sv
// Nearest-word edit distance: a row of DP cells, one per query position, plus search control.
// Each dictionary character enters the row at cell zero and walks it one cell a cycle;
// the characters of a word may enter back to back, one per cycle, as s_tready never holds them.
// Query commands and word end wait until the row has drained (word end also for a free output);
// the result of a word end appears in the output register on the next cycle.
// Reset (rst_n, async low) sets DP entry j to j, clears lengths, counts and best distance.
module nearest_word_edit_distance_top
    import nwed_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // ch[7:0]
    input  logic [IN_USER_W-1:0]  s_tuser,   // cmd[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // distance[6:0], best_distance[13:7],
                                             // word_index[33:14], zero[39:34]
    output logic [OUT_USER_W-1:0] m_tuser    // verdict[1:0], too_long[2]
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);

    cmd_t              cmd;
    logic [CH_W-1:0]   ch;
    logic              busy;
    logic [MAX_LEN-1:0] busy_vec;
    logic              acc;
    logic              acc_qchar;
    logic              acc_qend;
    logic              acc_dchar;
    logic              acc_dend;
    logic              clear;

    logic [LEN_W-1:0]  qlen_reg, qlen_next, qlen_eff;
    logic              qovf_reg, qovf_next;
    logic              qclosed_reg, qclosed_next;
    logic [LEN_W-1:0]  wlen_reg, wlen_next;
    logic              wovf_reg, wovf_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic              have_best_reg, have_best_next;
    logic [COUNT_W-1:0] wcount_reg, wcount_next;
    logic [DIST_W-1:0] dp0_reg, dp0_next;

    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] out_dist_reg;
    logic [DIST_W-1:0] out_best_reg;
    verdict_t          out_verdict_reg;
    logic [COUNT_W-1:0] out_index_reg;
    logic              out_long_reg;

    logic              word_go;
    logic [DIST_W-1:0] word_dist;
    verdict_t          verdict;
    logic [MAX_LEN:0][DIST_W-1:0] dp_vec;
    nwed_token_t       tok [0:MAX_LEN];
    logic [MAX_LEN-1:0] q_we;

    assign cmd = cmd_t'(s_tuser[1:0]);
    assign ch  = s_tdata[CH_W-1:0];

    // Dictionary characters stream in; others wait for a drained row, word end also for free output
    always_comb
    begin
        case (cmd)
            CMD_DCHAR: s_tready = 1'b1;
            CMD_DEND:  s_tready = !busy && (!out_valid_reg || m_tready);
            default:   s_tready = !busy;
        endcase
    end

    assign acc       = s_tvalid && s_tready;
    assign acc_qchar = acc && (cmd == CMD_QCHAR);
    assign acc_qend  = acc && (cmd == CMD_QEND);
    assign acc_dchar = acc && (cmd == CMD_DCHAR);
    assign acc_dend  = acc && (cmd == CMD_DEND);
    assign clear     = acc_qchar || acc_qend || acc_dend;
    assign qlen_eff  = qclosed_reg ? '0 : qlen_reg;
    assign word_go   = acc_dchar && (wlen_reg < LEN_MAX);

    // Cell zero: column of the empty query prefix
    assign dp0_next = sat_add(dp0_reg, INDEL_COST);
    assign tok[0].valid = word_go;
    assign tok[0].ch    = ch;
    assign tok[0].diag  = dp0_reg;
    assign tok[0].left  = dp0_next;
    assign dp_vec[0]    = dp0_reg;

    genvar j;
    generate
        for (j = 1; j <= MAX_LEN; j++)
        begin : g_cell
            assign q_we[j-1] = acc_qchar && (qlen_eff == LEN_W'(j - 1));
            assign busy_vec[j-1] = tok[j].valid;

            nwed_cell #(
                .INDEX (j)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .clear   (clear),
                .q_we    (q_we[j-1]),
                .q_ch    (ch),
                .tok_in  (tok[j-1]),
                .tok_out (tok[j]),
                .dp      (dp_vec[j])
            );
        end
    endgenerate

    assign busy      = |busy_vec;
    assign word_dist = dp_vec[qlen_reg];

    always_comb
    begin
        qlen_next      = qlen_reg;
        qovf_next      = qovf_reg;
        qclosed_next   = qclosed_reg;
        wlen_next      = wlen_reg;
        wovf_next      = wovf_reg;
        best_next      = best_reg;
        have_best_next = have_best_reg;
        wcount_next    = wcount_reg;
        verdict        = VERDICT_WORSE;

        if (acc_qchar)
        begin
            qclosed_next = 1'b0;
            if (qlen_eff < LEN_MAX)
            begin
                qlen_next = qlen_eff + LEN_W'(1);
                qovf_next = qclosed_reg ? 1'b0 : qovf_reg;
            end
            else
            begin
                qlen_next = qlen_eff;
                qovf_next = 1'b1;
            end
        end

        if (acc_qend)
        begin
            qclosed_next   = 1'b1;
            have_best_next = 1'b0;
            best_next      = '0;
            wcount_next    = '0;
        end

        if (acc_dchar)
        begin
            if (word_go)
                wlen_next = wlen_reg + LEN_W'(1);
            else
                wovf_next = 1'b1;
        end

        if (acc_dend)
        begin
            if (!have_best_reg || word_dist < best_reg)
            begin
                verdict        = VERDICT_NEW;
                best_next      = word_dist;
                have_best_next = 1'b1;
            end
            else if (word_dist == best_reg)
                verdict = VERDICT_TIE;
            else
                verdict = VERDICT_WORSE;
            if (wcount_reg != COUNT_MAX)
                wcount_next = wcount_reg + COUNT_W'(1);
        end

        // Drop the open word on any command that ends or discards it
        if (clear)
        begin
            wlen_next = '0;
            wovf_next = 1'b0;
        end
    end

    always_comb
    begin
        if (acc_dend)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            qovf_reg      <= 1'b0;
            qclosed_reg   <= 1'b0;
            wlen_reg      <= '0;
            wovf_reg      <= 1'b0;
            best_reg      <= '0;
            have_best_reg <= 1'b0;
            wcount_reg    <= '0;
            dp0_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            qlen_reg      <= qlen_next;
            qovf_reg      <= qovf_next;
            qclosed_reg   <= qclosed_next;
            wlen_reg      <= wlen_next;
            wovf_reg      <= wovf_next;
            best_reg      <= best_next;
            have_best_reg <= have_best_next;
            wcount_reg    <= wcount_next;
            out_valid_reg <= out_valid_next;
            if (clear)
                dp0_reg <= '0;
            else if (word_go)
                dp0_reg <= dp0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_dend)
        begin
            out_dist_reg    <= word_dist;
            out_best_reg    <= best_next;
            out_verdict_reg <= verdict;
            out_index_reg   <= wcount_reg;
            out_long_reg    <= qovf_reg || wovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - 2*DIST_W - COUNT_W){1'b0}},
                       out_index_reg, out_best_reg, out_dist_reg};
    assign m_tuser  = {out_long_reg, out_verdict_reg};

endmodule

>>> rtl/core/nwed_cell.sv
// One query position: holds its query character and DP entry, updates on a passing word.
module nwed_cell
    import nwed_pkg::*;
#(
    parameter int INDEX = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              q_we,
    input  logic [CH_W-1:0]   q_ch,
    input  nwed_token_t       tok_in,
    output nwed_token_t       tok_out,
    output logic [DIST_W-1:0] dp
);

    localparam logic [DIST_W-1:0] INIT =
        DIST_W'((INDEX > int'(DIST_MAX)) ? int'(DIST_MAX) : INDEX);

    logic [CH_W-1:0]   q_reg;
    logic [DIST_W-1:0] dp_reg;
    logic [DIST_W-1:0] dp_next;
    nwed_token_t       tok_reg;
    logic [DIST_W-1:0] sub_cost;

    always_comb
    begin
        sub_cost = sat_add(tok_reg.diag, (q_reg == tok_reg.ch) ? 2'd0 : SUB_COST);
        dp_next  = min3(sat_add(dp_reg, INDEL_COST), sat_add(tok_reg.left, INDEL_COST),
                        sub_cost);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg  <= INIT;
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (clear)
                dp_reg <= INIT;
            else if (tok_reg.valid)
                dp_reg <= dp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_reg <= q_ch;
    end

    // Hand the old entry on as the next cell's diagonal, the new one as its left
    assign tok_out.valid = tok_reg.valid;
    assign tok_out.ch    = tok_reg.ch;
    assign tok_out.diag  = dp_reg;
    assign tok_out.left  = dp_next;
    assign dp            = dp_reg;

endmodule
